// ----- hdl/mvsm_pkg.sv -----
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants of the multi-voice sample mixer: item kinds,
// fixed field widths and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mvsm_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_MIX   = 2'd3;

  localparam int RATE_W = 18;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  localparam int DIV_W  = 42;
  localparam int DCNT_W = 6;
  localparam int PROD_W = 51;

  typedef struct packed {
    logic load_in;
    logic idx_inc;
    logic vchk;
    logic smp0;
    logic smp1;
    logic mul_l;
    logic mul_r;
    logic gain_l;
    logic gain_r;
    logic wb;
    logic prod;
    logic div_init;
    logic div_step;
    logic start_wr;
    logic stop_do;
    logic wr_smp;
    logic res_load;
  } mvsm_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       idx_free;
    logic       idx_last;
    logic       div_last;
    logic       out_busy;
  } mvsm_sts_t;

endpackage

// ----- hdl/multi_voice_sample_mixer_unit.sv -----
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_unit
// Stereo sample playback mixer: sample memory writes, voice start and stop,
// and one linearly interpolated, gain scaled, saturated mix frame per item.
//
//   Channel  Ports                        Direction  Handshake
//   in       in_kind .. in_voice          sink       in_valid / in_stall
//   out      out_started .. out_active_*  source     out_valid / out_stall
//   cfg      cfg_wr_data (output rate)    sink       cfg_wr_en
//
// One item is worked on at a time. A start scans voices one per cycle for a
// free one, then runs a shift-subtract divider for its step. A mix walks every
// voice and reads the samples of each playing one through the single sample
// memory read port. The result register lets the next item be taken while a
// result is stalled. Reset is synchronous and clears all voices and the count.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer_unit #(
  parameter int VOICES       = 64,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [17:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [15:0]        in_address,
  input  logic signed [15:0] in_left_in,
  input  logic signed [15:0] in_right_in,
  input  logic [16:0]        in_length,
  input  logic [17:0]        in_source_rate,
  input  logic [15:0]        in_pitch,
  input  logic [15:0]        in_gain,
  input  logic [5:0]         in_voice,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_started,
  output logic [5:0]         out_voice_id,
  output logic signed [15:0] out_left_out,
  output logic signed [15:0] out_right_out,
  output logic [6:0]         out_active_voices
);

  mvsm_pkg::mvsm_cmd_t cmd;
  mvsm_pkg::mvsm_sts_t sts;

  mvsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mvsm_datapath #(
    .VOICES       (VOICES),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_kind           (in_kind),
    .in_address        (in_address),
    .in_left_in        (in_left_in),
    .in_right_in       (in_right_in),
    .in_length         (in_length),
    .in_source_rate    (in_source_rate),
    .in_pitch          (in_pitch),
    .in_gain           (in_gain),
    .in_voice          (in_voice),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_started       (out_started),
    .out_voice_id      (out_voice_id),
    .out_left_out      (out_left_out),
    .out_right_out     (out_right_out),
    .out_active_voices (out_active_voices)
  );

endmodule

// ----- hdl/mvsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// mvsm_ctrl
// Sequencer of the mixer. It decodes each item and steps the datapath
// through sample writes, voice allocation, voice stops and the mix walk.
// ----------------------------------------------------------------------------
module mvsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mvsm_pkg::mvsm_sts_t sts,
  output mvsm_pkg::mvsm_cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_FIND = 5'd2;
  localparam logic [4:0] S_MUL  = 5'd3;
  localparam logic [4:0] S_DIVI = 5'd4;
  localparam logic [4:0] S_DIV  = 5'd5;
  localparam logic [4:0] S_SWR  = 5'd6;
  localparam logic [4:0] S_VRD  = 5'd7;
  localparam logic [4:0] S_VCHK = 5'd8;
  localparam logic [4:0] S_SA   = 5'd9;
  localparam logic [4:0] S_SB   = 5'd10;
  localparam logic [4:0] S_SC   = 5'd11;
  localparam logic [4:0] S_ML   = 5'd12;
  localparam logic [4:0] S_MR   = 5'd13;
  localparam logic [4:0] S_GL   = 5'd14;
  localparam logic [4:0] S_GR   = 5'd15;
  localparam logic [4:0] S_WB   = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.kind)
          mvsm_pkg::KIND_WRITE: begin
            cmd.wr_smp = 1'b1;
            state_nxt  = S_DONE;
          end
          mvsm_pkg::KIND_START: state_nxt = S_FIND;
          mvsm_pkg::KIND_STOP: begin
            cmd.stop_do = 1'b1;
            state_nxt   = S_DONE;
          end
          default: state_nxt = S_VRD;
        endcase
      end
      S_FIND: begin
        if (sts.idx_free) begin
          state_nxt = S_MUL;
        end else if (sts.idx_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_MUL: begin
        cmd.prod  = 1'b1;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_SWR;
        end
      end
      S_SWR: begin
        cmd.start_wr = 1'b1;
        state_nxt    = S_DONE;
      end
      S_VRD: state_nxt = S_VCHK;
      S_VCHK: begin
        if (!sts.idx_free) begin
          cmd.vchk  = 1'b1;
          state_nxt = S_SA;
        end else if (sts.idx_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_VRD;
        end
      end
      S_SA: state_nxt = S_SB;
      S_SB: begin
        cmd.smp0  = 1'b1;
        cmd.smp1  = 1'b1;
        state_nxt = S_SC;
      end
      S_SC: begin
        cmd.smp1  = 1'b1;
        state_nxt = S_ML;
      end
      S_ML: begin
        cmd.mul_l = 1'b1;
        state_nxt = S_MR;
      end
      S_MR: begin
        cmd.mul_r = 1'b1;
        state_nxt = S_GL;
      end
      S_GL: begin
        cmd.gain_l = 1'b1;
        state_nxt  = S_GR;
      end
      S_GR: begin
        cmd.gain_r = 1'b1;
        state_nxt  = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_VRD;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/mvsm_datapath.sv -----
// ----------------------------------------------------------------------------
// mvsm_datapath
// Sample memory, voice tables, step divider, interpolation and gain
// multipliers, mix accumulators and the result register.
// ----------------------------------------------------------------------------
module mvsm_datapath #(
  parameter int VOICES       = 64,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mvsm_pkg::mvsm_cmd_t          cmd,
  output mvsm_pkg::mvsm_sts_t          sts,
  input  logic                         cfg_wr_en,
  input  logic [mvsm_pkg::RATE_W-1:0]  cfg_wr_data,
  input  logic [1:0]                   in_kind,
  input  logic [15:0]                  in_address,
  input  logic signed [15:0]           in_left_in,
  input  logic signed [15:0]           in_right_in,
  input  logic [16:0]                  in_length,
  input  logic [17:0]                  in_source_rate,
  input  logic [15:0]                  in_pitch,
  input  logic [15:0]                  in_gain,
  input  logic [5:0]                   in_voice,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_started,
  output logic [5:0]                   out_voice_id,
  output logic signed [15:0]           out_left_out,
  output logic signed [15:0]           out_right_out,
  output logic [6:0]                   out_active_voices
);

  localparam int VIW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW    = $clog2(SAMPLE_DEPTH);
  localparam int CW    = $clog2(VOICES + 1);
  localparam int ACC_W = mvsm_pkg::PROD_W + VIW + 1;

  logic [mvsm_pkg::RATE_W-1:0] rate_r;

  logic [1:0]         kind_r;
  logic [15:0]        addr_r;
  logic signed [15:0] left_r;
  logic signed [15:0] right_r;
  logic [16:0]        len_r;
  logic [17:0]        srate_r;
  logic [15:0]        pitch_r;
  logic [15:0]        gain_r;
  logic [5:0]         voice_r;

  logic [31:0] smp_mem [SAMPLE_DEPTH];
  logic [31:0] smp_rd_r;
  logic [AW-1:0] smp_raddr;

  logic [15:0] v_gain [VOICES];
  logic [31:0] v_step [VOICES];
  logic [31:0] v_cur  [VOICES];
  logic [15:0] v_base [VOICES];
  logic [16:0] v_len  [VOICES];
  logic [15:0] gain_q;
  logic [31:0] step_q;
  logic [31:0] cur_q;
  logic [15:0] base_q;
  logic [16:0] len_q;
  logic [31:0] cur_wdata;

  logic [VOICES-1:0] playing_r;
  logic [VIW-1:0]    idx_r;
  logic [CW-1:0]     count_r;
  logic              started_r;

  logic [33:0]                 prod_r;
  logic [mvsm_pkg::DIV_W-1:0]  dvd_r;
  logic [17:0]                 rem_r;
  logic [mvsm_pkg::DCNT_W-1:0] dcnt_r;
  logic [18:0]                 rem_sh;
  logic                        div_ge;
  logic [31:0]                 step_sat;

  logic [AW-1:0]      a_r;
  logic [15:0]        fr_r;
  logic               rng0_r;
  logic               rng1_r;
  logic signed [15:0] l0_r;
  logic signed [15:0] r0_r;
  logic signed [15:0] l1_r;
  logic signed [15:0] r1_r;
  logic signed [33:0] il_r;
  logic signed [33:0] ir_r;
  logic signed [mvsm_pkg::PROD_W-1:0] gl_r;
  logic signed [mvsm_pkg::PROD_W-1:0] gr_r;
  logic signed [ACC_W-1:0] accl_r;
  logic signed [ACC_W-1:0] accr_r;

  logic [16:0]        ci_ext;
  logic signed [16:0] fr_s;
  logic signed [16:0] dl;
  logic signed [16:0] dr;
  logic signed [16:0] gain_s;
  logic [32:0]        nc_sum;
  logic [31:0]        nc;
  logic               v_end;
  logic               stop_hit;
  logic signed [15:0] qs_l;
  logic signed [15:0] qs_r;

  logic               out_valid_r;
  logic               started_o_r;
  logic [5:0]         vid_o_r;
  logic signed [15:0] left_o_r;
  logic signed [15:0] right_o_r;
  logic [6:0]         count_o_r;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = acc >>> 28;
    if (sh > ACC_W'(32767)) begin
      return 16'sd32767;
    end else if (sh < ACC_W'(-32768)) begin
      return -16'sd32768;
    end else begin
      return sh[15:0];
    end
  endfunction

  assign sts.kind     = kind_r;
  assign sts.idx_free = !playing_r[idx_r];
  assign sts.idx_last = (idx_r == VIW'(VOICES - 1));
  assign sts.div_last = (dcnt_r == mvsm_pkg::DCNT_W'(mvsm_pkg::DIV_W - 1));
  assign sts.out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= mvsm_pkg::RATE_RESET;
    end else if (cfg_wr_en) begin
      rate_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= in_kind;
      addr_r  <= in_address;
      left_r  <= in_left_in;
      right_r <= in_right_in;
      len_r   <= in_length;
      srate_r <= in_source_rate;
      pitch_r <= in_pitch;
      gain_r  <= in_gain;
      voice_r <= in_voice;
    end
  end

  assign smp_raddr = (cmd.smp1 && !cmd.smp0) ? AW'(a_r + AW'(1)) :
                     (cmd.smp0 ? AW'(a_r + AW'(1)) : a_r);

  always_ff @(posedge clk) begin
    if (cmd.wr_smp) begin
      smp_mem[AW'(addr_r)] <= {right_r, left_r};
    end
    smp_rd_r <= smp_mem[smp_raddr];
  end

  assign cur_wdata = cmd.start_wr ? 32'd0 : nc;

  always_ff @(posedge clk) begin
    if (cmd.start_wr) begin
      v_gain[idx_r] <= gain_r;
      v_step[idx_r] <= step_sat;
      v_base[idx_r] <= addr_r;
      v_len[idx_r]  <= len_r;
    end
    if (cmd.start_wr || cmd.wb) begin
      v_cur[idx_r] <= cur_wdata;
    end
    gain_q <= v_gain[idx_r];
    step_q <= v_step[idx_r];
    cur_q  <= v_cur[idx_r];
    base_q <= v_base[idx_r];
    len_q  <= v_len[idx_r];
  end

  assign rem_sh   = {rem_r, dvd_r[mvsm_pkg::DIV_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, rate_r});
  assign step_sat = ((rate_r == '0) || (|dvd_r[mvsm_pkg::DIV_W-1:32])) ? 32'hFFFF_FFFF
                                                                       : dvd_r[31:0];

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      prod_r <= srate_r * pitch_r;
    end
    if (cmd.div_init) begin
      dvd_r  <= {prod_r, 8'd0};
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[mvsm_pkg::DIV_W-2:0], div_ge};
      rem_r  <= div_ge ? 18'(rem_sh - {1'b0, rate_r}) : rem_sh[17:0];
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  assign ci_ext = {1'b0, cur_q[31:16]};
  assign fr_s   = $signed({1'b0, fr_r});
  assign dl     = 17'(l1_r) - 17'(l0_r);
  assign dr     = 17'(r1_r) - 17'(r0_r);
  assign gain_s = $signed({1'b0, gain_q});
  assign nc_sum = {1'b0, cur_q} + {1'b0, step_q};
  assign nc     = nc_sum[32] ? 32'hFFFF_FFFF : nc_sum[31:0];
  assign v_end  = ({2'b00, nc[31:16]} + 18'd2) >= {1'b0, len_q};

  always_ff @(posedge clk) begin
    if (cmd.vchk) begin
      a_r    <= AW'({1'b0, base_q} + ci_ext);
      fr_r   <= cur_q[15:0];
      rng0_r <= ci_ext < len_q;
      rng1_r <= ({1'b0, ci_ext} + 18'd1) < {1'b0, len_q};
    end
    if (cmd.smp0) begin
      l0_r <= rng0_r ? smp_rd_r[15:0]  : 16'sd0;
      r0_r <= rng0_r ? smp_rd_r[31:16] : 16'sd0;
    end
    if (cmd.smp1 && !cmd.smp0) begin
      l1_r <= (rng0_r && rng1_r) ? smp_rd_r[15:0]  : 16'sd0;
      r1_r <= (rng0_r && rng1_r) ? smp_rd_r[31:16] : 16'sd0;
    end
    if (cmd.mul_l) begin
      il_r <= (34'(l0_r) <<< 16) + 34'(dl * fr_s);
    end
    if (cmd.mul_r) begin
      ir_r <= (34'(r0_r) <<< 16) + 34'(dr * fr_s);
    end
    if (cmd.gain_l) begin
      gl_r <= mvsm_pkg::PROD_W'(il_r * gain_s);
    end
    if (cmd.gain_r) begin
      gr_r <= mvsm_pkg::PROD_W'(ir_r * gain_s);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      accl_r <= '0;
      accr_r <= '0;
    end else begin
      if (cmd.gain_r) begin
        accl_r <= accl_r + ACC_W'(gl_r);
      end
      if (cmd.wb) begin
        accr_r <= accr_r + ACC_W'(gr_r);
      end
    end
  end

  assign stop_hit = ({3'b000, voice_r} < 9'(VOICES)) && playing_r[VIW'(voice_r)];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= '0;
      count_r   <= '0;
      idx_r     <= '0;
      started_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        idx_r     <= '0;
        started_r <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.start_wr) begin
        playing_r[idx_r] <= 1'b1;
        count_r          <= count_r + 1'b1;
        started_r        <= 1'b1;
      end
      if (cmd.stop_do && stop_hit) begin
        playing_r[VIW'(voice_r)] <= 1'b0;
        if (count_r != '0) begin
          count_r <= count_r - 1'b1;
        end
      end
      if (cmd.wb && v_end) begin
        playing_r[idx_r] <= 1'b0;
        if (count_r != '0) begin
          count_r <= count_r - 1'b1;
        end
      end
    end
  end

  assign qs_l = sat16(accl_r);
  assign qs_r = sat16(accr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      started_o_r <= started_r;
      vid_o_r     <= started_r ? 6'(idx_r) : 6'd0;
      left_o_r    <= qs_l;
      right_o_r   <= qs_r;
      count_o_r   <= 7'(count_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_started       = started_o_r;
  assign out_voice_id      = vid_o_r;
  assign out_left_out      = left_o_r;
  assign out_right_out     = right_o_r;
  assign out_active_voices = count_o_r;

endmodule

// ----- dv/multi_voice_sample_mixer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_unit_tb
// Self-checking testbench of the multi-voice sample mixer. A directed table
// and constrained-by-hand random traffic drive sample writes, voice starts,
// stops and mix frames through a valid/stall channel. A behavioral model of
// the voices, sample memory and mix arithmetic predicts every result, and
// each output transfer is compared field by field with the oldest
// prediction. The output rate is reprogrammed between phases.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVOICE  = 64;
  localparam int WDOG    = 200000;
  localparam int REGION  = 256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [15:0] left_in;
    logic [15:0] right_in;
    logic [16:0] length;
    logic [17:0] source_rate;
    logic [15:0] pitch;
    logic [15:0] gain;
    logic [5:0]  voice;
  } mix_item_t;

  typedef struct packed {
    logic        started;
    logic [5:0]  voice_id;
    logic [15:0] left_out;
    logic [15:0] right_out;
    logic [6:0]  active_voices;
  } mix_res_t;

  typedef struct {
    mix_item_t item;
    logic      chk;
    mix_res_t  res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [17:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  mix_item_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_started;
  logic [5:0] out_voice_id;
  logic signed [15:0] out_left_out, out_right_out;
  logic [6:0] out_active_voices;

  always #2 clk = ~clk;

  multi_voice_sample_mixer_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(drv.kind),
    .in_address(drv.address), .in_left_in(drv.left_in), .in_right_in(drv.right_in),
    .in_length(drv.length), .in_source_rate(drv.source_rate), .in_pitch(drv.pitch),
    .in_gain(drv.gain), .in_voice(drv.voice), .out_valid(out_valid),
    .out_stall(out_stall), .out_started(out_started), .out_voice_id(out_voice_id),
    .out_left_out(out_left_out), .out_right_out(out_right_out),
    .out_active_voices(out_active_voices)
  );

  // Predictor state.
  logic [31:0] mem_word [int];
  logic        v_play [NVOICE];
  logic [15:0] v_gain [NVOICE];
  logic [31:0] v_step [NVOICE];
  logic [31:0] v_cur [NVOICE];
  logic [15:0] v_base [NVOICE];
  logic [16:0] v_len [NVOICE];
  int          n_active;
  logic [17:0] rate_reg;

  mix_res_t    pending_results [$];
  logic        pending_fixed [$];
  mix_res_t    pending_fixed_val [$];
  int          errors = 0;
  int          idle_cnt = 0;
  int          in_idle_pct = 0, out_idle_pct = 0;

  function automatic longint sample_half(logic [31:0] w, bit right);
    return right ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
  endfunction

  function automatic logic [15:0] q15_sat(longint acc);
    longint q;
    q = acc >>> 28;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic mix_res_t mixer_predict(mix_item_t it);
    mix_res_t r;
    longint unsigned num, st, nc;
    longint accl, accr, l0, r0, l1, r1, fr;
    int ci, a;
    r = '0;
    case (it.kind)
      mvsm_pkg::KIND_WRITE: mem_word[it.address] = {it.right_in, it.left_in};
      mvsm_pkg::KIND_START: begin
        for (int i = 0; i < NVOICE; i++) begin
          if (!v_play[i]) begin
            num = longint'(it.source_rate) * longint'(it.pitch) * 256;
            if (rate_reg == 0) st = 64'hFFFFFFFF;
            else st = num / rate_reg;
            if (st > 64'hFFFFFFFF) st = 64'hFFFFFFFF;
            v_step[i] = st[31:0];
            v_gain[i] = it.gain;
            v_base[i] = it.address;
            v_len[i] = it.length;
            v_cur[i] = '0;
            v_play[i] = 1'b1;
            n_active++;
            r.started = 1'b1;
            r.voice_id = i[5:0];
            break;
          end
        end
      end
      mvsm_pkg::KIND_STOP: begin
        if (v_play[it.voice]) begin
          v_play[it.voice] = 1'b0;
          if (n_active > 0) n_active--;
        end
      end
      default: begin
        accl = 0;
        accr = 0;
        for (int i = 0; i < NVOICE; i++) begin
          if (!v_play[i]) continue;
          ci = int'(v_cur[i][31:16]);
          fr = longint'(v_cur[i][15:0]);
          if (ci < v_len[i]) begin
            a = (v_base[i] + ci) % 65536;
            l0 = mem_word.exists(a) ? sample_half(mem_word[a], 0) : 0;
            r0 = mem_word.exists(a) ? sample_half(mem_word[a], 1) : 0;
            l1 = 0;
            r1 = 0;
            if (ci + 1 < v_len[i]) begin
              a = (a + 1) % 65536;
              l1 = mem_word.exists(a) ? sample_half(mem_word[a], 0) : 0;
              r1 = mem_word.exists(a) ? sample_half(mem_word[a], 1) : 0;
            end
            accl += (l0 * (65536 - fr) + l1 * fr) * longint'(v_gain[i]);
            accr += (r0 * (65536 - fr) + r1 * fr) * longint'(v_gain[i]);
          end
          nc = longint'(v_cur[i]) + longint'(v_step[i]);
          if (nc > 64'hFFFFFFFF) nc = 64'hFFFFFFFF;
          v_cur[i] = nc[31:0];
          if (longint'(nc >> 16) + 1 >= longint'(v_len[i]) - 1) begin
            v_play[i] = 1'b0;
            if (n_active > 0) n_active--;
          end
        end
        r.left_out = q15_sat(accl);
        r.right_out = q15_sat(accr);
      end
    endcase
    r.active_voices = n_active[6:0];
    return r;
  endfunction

  // Samples are kept inside a written window so no unwritten entry is read.
  function automatic mix_item_t random_item(int wr_bias);
    mix_item_t it;
    int sel;
    it = '0;
    sel = $urandom_range(99);
    if (sel < wr_bias) it.kind = mvsm_pkg::KIND_WRITE;
    else if (sel < wr_bias + 25) it.kind = mvsm_pkg::KIND_START;
    else if (sel < wr_bias + 35) it.kind = mvsm_pkg::KIND_STOP;
    else it.kind = mvsm_pkg::KIND_MIX;
    it.left_in = 16'($urandom);
    it.right_in = 16'($urandom);
    it.voice = 6'($urandom);
    it.gain = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8192));
    it.pitch = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
    it.source_rate = ($urandom_range(7) == 0) ? 18'($urandom_range(262143))
                                               : 18'($urandom_range(96000, 1));
    case (it.kind)
      mvsm_pkg::KIND_WRITE: it.address = ($urandom_range(9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(REGION - 1));
      mvsm_pkg::KIND_START: begin
        it.length = 17'($urandom_range(REGION));
        it.address = 16'($urandom_range(REGION - it.length));
        if (it.length == REGION && $urandom_range(1)) begin
          it.address = 16'hFF80;
          it.length = 17'd128;
        end
      end
      default: it.address = 16'($urandom);
    endcase
    if (it.kind != mvsm_pkg::KIND_START) it.length = 17'($urandom_range(131071));
    return it;
  endfunction

  task automatic write_rate(logic [17:0] val);
    repeat (120) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rate_reg = val;
  endtask

  task automatic send_item(mix_item_t it, logic chk, mix_res_t fixed);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    drv <= it;
    in_valid <= 1'b1;
    pending_results.push_back(mixer_predict(it));
    pending_fixed.push_back(chk);
    pending_fixed_val.push_back(fixed);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < out_idle_pct);

  always @(posedge clk) begin
    mix_res_t got, want;
    logic fixed_chk;
    mix_res_t fixed_val;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_started, out_voice_id, out_left_out, out_right_out, out_active_voices};
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        fixed_chk = pending_fixed.pop_front();
        fixed_val = pending_fixed_val.pop_front();
        if (fixed_chk && fixed_val != want) begin
          $error("table row disagrees with predictor: %h vs %h", fixed_val, want);
          errors++;
        end
        if (got.started != want.started) begin
          $error("started: expected %0d actual %0d", want.started, got.started);
          errors++;
        end
        if (got.voice_id != want.voice_id) begin
          $error("voice_id: expected %0d actual %0d", want.voice_id, got.voice_id);
          errors++;
        end
        if (got.left_out != want.left_out) begin
          $error("left_out: expected %0d actual %0d",
                 $signed(want.left_out), $signed(got.left_out));
          errors++;
        end
        if (got.right_out != want.right_out) begin
          $error("right_out: expected %0d actual %0d",
                 $signed(want.right_out), $signed(got.right_out));
          errors++;
        end
        if (got.active_voices != want.active_voices) begin
          $error("active_voices: expected %0d actual %0d",
                 want.active_voices, got.active_voices);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cnt >= WDOG) begin
      $display("multi_voice_sample_mixer_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic table_row_t row(logic [1:0] k, logic [15:0] ad, logic [15:0] l,
                                     logic [15:0] r, logic [16:0] len, logic [17:0] sr,
                                     logic [15:0] p, logic [15:0] g, logic [5:0] v,
                                     logic chk, mix_res_t res);
    table_row_t t;
    t.item = '{k, ad, l, r, len, sr, p, g, v};
    t.chk = chk;
    t.res = res;
    return t;
  endfunction

  initial begin
    table_row_t dir [$];
    mix_res_t z;
    mix_item_t it;
    logic [17:0] rates [5] = '{18'd8000, 18'd192000, 18'd44100, 18'd0, 18'd48000};
    z = '0;
    for (int i = 0; i < NVOICE; i++) v_play[i] = 1'b0;
    n_active = 0;
    rate_reg = mvsm_pkg::RATE_RESET;

    dir.push_back(row(mvsm_pkg::KIND_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 1, z));
    dir.push_back(row(mvsm_pkg::KIND_STOP, 0, 0, 0, 0, 0, 0, 0, 63, 1, z));
    dir.push_back(row(mvsm_pkg::KIND_WRITE, 0, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0, 1, z));
    dir.push_back(row(mvsm_pkg::KIND_WRITE, 1, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 0, 1, z));
    dir.push_back(row(mvsm_pkg::KIND_WRITE, 2, 16'h1234, 16'hEDCB, 0, 0, 0, 0, 0, 1, z));
    dir.push_back(row(mvsm_pkg::KIND_WRITE, 16'hFFFF, 16'h4000, 16'hC000, 0, 0, 0, 0, 0,
                      1, z));
    dir.push_back(row(mvsm_pkg::KIND_START, 0, 0, 0, 3, 48000, 128, 16'hFFFF, 0, 1,
                      '{1'b1, 6'd0, 16'd0, 16'd0, 7'd1}));
    dir.push_back(row(mvsm_pkg::KIND_START, 16'hFFFF, 0, 0, 2, 48000, 256, 4096, 0, 0, z));
    dir.push_back(row(mvsm_pkg::KIND_START, 0, 0, 0, 0, 1, 0, 4096, 0, 0, z));
    dir.push_back(row(mvsm_pkg::KIND_START, 1, 0, 0, 1, 192000, 16'hFFFF, 4096, 0, 0, z));
    dir.push_back(row(mvsm_pkg::KIND_START, 0, 0, 0, 3, 0, 256, 4096, 0, 0, z));
    dir.push_back(row(mvsm_pkg::KIND_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, z));
    dir.push_back(row(mvsm_pkg::KIND_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, z));
    dir.push_back(row(mvsm_pkg::KIND_STOP, 0, 0, 0, 0, 0, 0, 0, 4, 0, z));
    dir.push_back(row(mvsm_pkg::KIND_STOP, 0, 0, 0, 0, 0, 0, 0, 4, 0, z));
    dir.push_back(row(mvsm_pkg::KIND_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, z));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct = 14;
    out_idle_pct = 80;
    foreach (dir[i]) send_item(dir[i].item, dir[i].chk, dir[i].res);
    drain();

    // Fill the sample window, then exhaust the voices to force refusals.
    for (int a = 0; a < REGION; a++) begin
      it = '0;
      it.kind = mvsm_pkg::KIND_WRITE;
      it.address = 16'(a);
      it.left_in = 16'($urandom);
      it.right_in = 16'($urandom);
      send_item(it, 0, z);
    end
    for (int a = 16'hFF80; a <= 16'hFFFF; a++) begin
      it = '0;
      it.kind = mvsm_pkg::KIND_WRITE;
      it.address = 16'(a);
      it.left_in = 16'($urandom);
      it.right_in = 16'($urandom);
      send_item(it, 0, z);
    end
    for (int i = 0; i < NVOICE + 2; i++) begin
      it = '0;
      it.kind = mvsm_pkg::KIND_START;
      it.length = 17'd200;
      it.source_rate = '0;
      it.gain = 16'hFFFF;
      send_item(it, 0, z);
    end
    send_item(random_item(0), 0, z);
    drain();
    for (int i = 0; i < NVOICE; i++) begin
      it = '0;
      it.kind = mvsm_pkg::KIND_STOP;
      it.voice = 6'(i);
      send_item(it, 0, z);
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_rate(rates[ph]);
      if (ph == 2) begin
        in_idle_pct = 80;
        out_idle_pct = 14;
      end else if (ph == 4) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      for (int n = 0; n < 210; n++) begin
        send_item(random_item(15), 0, z);
        if (n == 105) drain();
      end
      drain();
      for (int i = 0; i < NVOICE; i++) begin
        it = '0;
        it.kind = mvsm_pkg::KIND_STOP;
        it.voice = 6'(i);
        send_item(it, 0, z);
      end
      drain();
    end

    repeat (200) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("multi_voice_sample_mixer_unit_tb: PASS");
    end else begin
      $display("multi_voice_sample_mixer_unit_tb: FAIL");
    end
    $finish;
  end
endmodule
